// File: sv/pool2d_pkg.sv
// Shared types and constants of the 2-D pooling block.
package pool2d_pkg;

    localparam int KW        = 4;   // window and stride register width
    localparam int DIM_W     = 7;   // plane height, width and channel count width
    localparam int IDX_W     = 6;   // row, column and channel index width
    localparam int PAD_W     = 4;   // padding amount width
    localparam int REG_W     = 7;   // widest configuration register
    localparam int REG_IDX_W = 3;   // configuration register index width
    localparam int DIM_MAX   = 64;  // largest plane side and channel count

    localparam logic [REG_IDX_W-1:0] REG_POOL_KIND     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAD_MODE      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE        = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd6;

    localparam logic KIND_MAX   = 1'b0;
    localparam logic KIND_AVG   = 1'b1;
    localparam logic MODE_VALID = 1'b0;
    localparam logic MODE_SAME  = 1'b1;

    // Output count and padding split along one axis
    typedef struct packed {
        logic [DIM_W-1:0] outn;
        logic [PAD_W-1:0] lead;
        logic [PAD_W-1:0] trail;
    } axis_geom_t;

    typedef enum logic [7:0] {
        ST_GEOM  = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_SETUP = 8'b0000_0100,
        ST_READ  = 8'b0000_1000,
        ST_DRAIN = 8'b0001_0000,
        ST_PUSH  = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } pool_state_t;

endpackage

// File: sv/pooling_2d_max_avg_unit.sv
// Streaming 2-D max and average pooling unit, top level.
//
// Samples of one channel plane enter on the s_axis channel in raster order, one per
// beat; planes of a frame follow one another. Each pooling window is reported on
// the m_axis channel after the beat that carries its last in-frame sample; the last
// result caused by a sample carries tlast. A sample that completes no window is
// taken, and the next beat can follow right after.
// A sample that completes windows holds s_axis_tready low while they are worked
// off one at a time: a window walks its stored samples through the line store's
// single read port (one sample per cycle, up to k*k), then passes the division
// chain, also for max pooling.
// A stalled receiver freezes the unit with the result held on m_axis.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once, restart
// the frame position and trigger a geometry pass during which no sample is
// accepted. The same pass runs after reset, which loads the register
// defaults: max pooling, valid mode, 2x2 window, stride 2, 64x64 plane, 1 channel.
module pooling_2d_max_avg_unit #(
    parameter int MAX_WINDOW  = 8,
    parameter int MAX_WIDTH   = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // pooled_value, out_channel, out_row, out_col
    output logic [((SAMPLE_BITS+18+7)/8)*8-1:0] m_axis_tdata,
    output logic m_axis_tlast,
    input  logic cfg_we,
    input  logic [pool2d_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [pool2d_pkg::REG_W-1:0] cfg_data
);
    import pool2d_pkg::*;

    localparam int OUT_W  = ((SAMPLE_BITS + 18 + 7) / 8) * 8;
    localparam int SUM_W  = SAMPLE_BITS + 2 * KW;
    localparam int NUM_W  = SUM_W + 1;
    localparam int DEN_W  = 2 * KW + 1;
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CIDX_W = $clog2(MAX_WIDTH);
    localparam int W_MAX  = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
    localparam int SAT_HI = 2 ** (SAMPLE_BITS - 1) - 1;

    // configuration
    logic             kind_reg, kind_next;
    logic             mode_reg, mode_next;
    logic [KW-1:0]    ws_reg, ws_next;
    logic [KW-1:0]    st_reg, st_next;
    logic [DIM_W-1:0] ih_reg, ih_next;
    logic [DIM_W-1:0] iw_reg, iw_next;
    logic [DIM_W-1:0] ch_reg, ch_next;

    logic [KW-1:0]    k_eff, s_eff;
    logic [DIM_W-1:0] h_eff, w_eff, ch_eff;

    // control
    pool_state_t      state_reg, state_next;
    logic             start_reg, start_next;
    logic [IDX_W-1:0] prow_reg, prow_next;
    logic [IDX_W-1:0] pcol_reg, pcol_next;
    logic [IDX_W-1:0] plane_reg, plane_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [DIM_W-1:0] row_i_reg, row_i_next;
    logic [7:0]       row_end_reg, row_end_next;
    logic [DIM_W-1:0] col_j_reg, col_j_next;
    logic [7:0]       col_end_reg, col_end_next;
    logic             rd_v_reg, rd_v_next;

    // payload of the sample at work
    logic [IDX_W-1:0]  cur_r_reg, cur_r_next;
    logic [IDX_W-1:0]  cur_c_reg, cur_c_next;
    logic [IDX_W-1:0]  cur_ch_reg, cur_ch_next;
    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  i_hi_reg, i_hi_next;
    logic [IDX_W-1:0]  j_lo_reg, j_lo_next;
    logic [IDX_W-1:0]  j_hi_reg, j_hi_next;
    logic [IDX_W-1:0]  rr_reg, rr_next;
    logic [IDX_W-1:0]  cc_reg, cc_next;
    logic [IDX_W-1:0]  c0_reg, c0_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;
    logic [KW-1:0]     dr_reg, dr_next;
    logic [KW-1:0]     dc_reg, dc_next;
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic              first_reg, first_next;
    logic [SAMPLE_BITS-1:0] val_reg, val_next;

    axis_geom_t       row_g, col_g;
    logic             row_busy, col_busy;

    logic             in_fire, out_fire;
    logic             last_row, last_col, last_plane;
    logic             row_hit, col_hit;
    logic [7:0]       rend_init, cend_init;

    logic [9:0]       is_w, js_w;
    logic [IDX_W-1:0] r0_w, c0_w, diff_w;
    logic [7:0]       slot8_w;
    logic [KW-1:0]    dr_w, dc_w;

    logic [SAMPLE_BITS-1:0] rdata;
    logic signed [SUM_W-1:0] x_w;
    logic [SUM_W-1:0] mag_w;
    logic [2*KW-1:0]  den_w;
    logic             div_v;
    logic [NUM_W-1:0] quot;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // Effective configuration
    always_comb
    begin
        if (ws_reg == '0)
            k_eff = KW'(1);
        else if (int'(ws_reg) > MAX_WINDOW)
            k_eff = KW'(MAX_WINDOW);
        else
            k_eff = ws_reg;

        if (st_reg == '0)
            s_eff = KW'(1);
        else if (st_reg > k_eff)
            s_eff = k_eff;
        else
            s_eff = st_reg;

        if (ih_reg == '0)
            h_eff = DIM_W'(1);
        else if (int'(ih_reg) > DIM_MAX)
            h_eff = DIM_W'(DIM_MAX);
        else
            h_eff = ih_reg;

        if (iw_reg == '0)
            w_eff = DIM_W'(1);
        else if (int'(iw_reg) > W_MAX)
            w_eff = DIM_W'(W_MAX);
        else
            w_eff = iw_reg;

        if (ch_reg == '0)
            ch_eff = DIM_W'(1);
        else if (int'(ch_reg) > DIM_MAX)
            ch_eff = DIM_W'(DIM_MAX);
        else
            ch_eff = ch_reg;
    end

    pool2d_axis_geom u_row_geom (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .n     (h_eff),
        .k     (k_eff),
        .s     (s_eff),
        .same  (mode_reg),
        .busy  (row_busy),
        .geom  (row_g)
    );

    pool2d_axis_geom u_col_geom (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .n     (w_eff),
        .k     (k_eff),
        .s     (s_eff),
        .same  (mode_reg),
        .busy  (col_busy),
        .geom  (col_g)
    );

    pool2d_line_store #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (in_fire),
        .wslot (slot_reg),
        .wcol  (CIDX_W'(pcol_reg)),
        .wdata (s_axis_tdata[SAMPLE_BITS-1:0]),
        .rslot (rslot_reg),
        .rcol  (CIDX_W'(cc_reg)),
        .rdata (rdata)
    );

    assign mag_w = acc_reg[SUM_W-1] ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);
    assign den_w = {KW'(0), dr_reg} * {KW'(0), dc_reg};

    pool2d_div_chain #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (state_reg == ST_PUSH),
        .in_num    ({mag_w, 1'b0} + NUM_W'(den_w)),
        .in_den    ({den_w, 1'b0}),
        .out_valid (div_v),
        .out_quot  (quot)
    );

    // Frame position and window pointers
    always_comb
    begin
        last_row   = {1'b0, prow_reg} == (h_eff - 1'b1);
        last_col   = {1'b0, pcol_reg} == (w_eff - 1'b1);
        last_plane = {1'b0, plane_reg} == (ch_eff - 1'b1);
        rend_init  = {4'd0, k_eff} - 8'd1 - {4'd0, row_g.lead};
        cend_init  = {4'd0, k_eff} - 8'd1 - {4'd0, col_g.lead};
        row_hit    = (row_i_reg < row_g.outn)
                     && ((row_end_reg == {2'd0, prow_reg}) || last_row);
        col_hit    = (col_j_reg < col_g.outn)
                     && ((col_end_reg == {2'd0, pcol_reg}) || last_col);
    end

    // Window origin, divisors and first store slot for window (i, j)
    always_comb
    begin
        is_w   = {4'd0, i_reg} * {6'd0, s_eff};
        js_w   = {4'd0, j_reg} * {6'd0, s_eff};
        r0_w   = (is_w > {6'd0, row_g.lead}) ? IDX_W'(is_w - {6'd0, row_g.lead}) : '0;
        c0_w   = (js_w > {6'd0, col_g.lead}) ? IDX_W'(js_w - {6'd0, col_g.lead}) : '0;

        dr_w = k_eff;
        if (mode_reg == MODE_SAME)
        begin
            if ({1'b0, i_reg} < {3'd0, row_g.lead})
                dr_w = k_eff - row_g.lead;
            else if ({1'b0, is_w} + {7'd0, k_eff} > {7'd0, row_g.lead} + {4'd0, h_eff})
                dr_w = k_eff - row_g.trail;
        end
        dc_w = k_eff;
        if (mode_reg == MODE_SAME)
        begin
            if ({1'b0, j_reg} < {3'd0, col_g.lead})
                dc_w = k_eff - col_g.lead;
            else if ({1'b0, js_w} + {7'd0, k_eff} > {7'd0, col_g.lead} + {4'd0, w_eff})
                dc_w = k_eff - col_g.trail;
        end

        // step back from the current row's slot, wrapping around the store
        diff_w  = cur_r_reg - r0_w;
        slot8_w = (8'(cur_slot_reg) >= {2'd0, diff_w})
                  ? 8'(cur_slot_reg) - {2'd0, diff_w}
                  : 8'(cur_slot_reg) + 8'(MAX_WINDOW) - {2'd0, diff_w};
    end

    assign x_w = {{(SUM_W-SAMPLE_BITS){rdata[SAMPLE_BITS-1]}}, rdata};

    always_comb
    begin
        kind_next     = kind_reg;
        mode_next     = mode_reg;
        ws_next       = ws_reg;
        st_next       = st_reg;
        ih_next       = ih_reg;
        iw_next       = iw_reg;
        ch_next       = ch_reg;
        state_next    = state_reg;
        start_next    = 1'b0;
        prow_next     = prow_reg;
        pcol_next     = pcol_reg;
        plane_next    = plane_reg;
        slot_next     = slot_reg;
        row_i_next    = row_i_reg;
        row_end_next  = row_end_reg;
        col_j_next    = col_j_reg;
        col_end_next  = col_end_reg;
        rd_v_next     = 1'b0;
        cur_r_next    = cur_r_reg;
        cur_c_next    = cur_c_reg;
        cur_ch_next   = cur_ch_reg;
        cur_slot_next = cur_slot_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        i_hi_next     = i_hi_reg;
        j_lo_next     = j_lo_reg;
        j_hi_next     = j_hi_reg;
        rr_next       = rr_reg;
        cc_next       = cc_reg;
        c0_next       = c0_reg;
        rslot_next    = rslot_reg;
        dr_next       = dr_reg;
        dc_next       = dc_reg;
        acc_next      = acc_reg;
        first_next    = first_reg;
        val_next      = val_reg;

        // fold in the sample read in the previous cycle
        if (rd_v_reg)
        begin
            if (kind_reg == KIND_AVG)
                acc_next = acc_reg + x_w;
            else if (first_reg || (x_w > acc_reg))
                acc_next = x_w;
            first_next = 1'b0;
        end

        case (state_reg)
            ST_GEOM:
            begin
                if (!start_reg && !row_busy && !col_busy)
                begin
                    row_i_next   = '0;
                    row_end_next = rend_init;
                    col_j_next   = '0;
                    col_end_next = cend_init;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cur_r_next    = prow_reg;
                    cur_c_next    = pcol_reg;
                    cur_ch_next   = plane_reg;
                    cur_slot_next = slot_reg;
                    i_next        = IDX_W'(row_i_reg);
                    j_next        = IDX_W'(col_j_reg);
                    j_lo_next     = IDX_W'(col_j_reg);
                    i_hi_next     = last_row ? IDX_W'(row_g.outn - 1'b1) : IDX_W'(row_i_reg);
                    j_hi_next     = last_col ? IDX_W'(col_g.outn - 1'b1) : IDX_W'(col_j_reg);
                    if (row_hit && col_hit)
                        state_next = ST_SETUP;

                    // advance position and window pointers past this sample
                    if (last_col)
                    begin
                        pcol_next    = '0;
                        col_j_next   = '0;
                        col_end_next = cend_init;
                        if (last_row)
                        begin
                            prow_next    = '0;
                            slot_next    = '0;
                            row_i_next   = '0;
                            row_end_next = rend_init;
                            plane_next   = last_plane ? '0 : plane_reg + 1'b1;
                        end
                        else
                        begin
                            prow_next = prow_reg + 1'b1;
                            slot_next = (slot_reg == SLOT_W'(MAX_WINDOW - 1))
                                        ? '0 : slot_reg + 1'b1;
                            if (row_end_reg == {2'd0, prow_reg})
                            begin
                                row_i_next   = row_i_reg + 1'b1;
                                row_end_next = row_end_reg + {4'd0, s_eff};
                            end
                        end
                    end
                    else
                    begin
                        pcol_next = pcol_reg + 1'b1;
                        if (col_end_reg == {2'd0, pcol_reg})
                        begin
                            col_j_next   = col_j_reg + 1'b1;
                            col_end_next = col_end_reg + {4'd0, s_eff};
                        end
                    end
                end
            end
            ST_SETUP:
            begin
                rr_next    = r0_w;
                cc_next    = c0_w;
                c0_next    = c0_w;
                rslot_next = SLOT_W'(slot8_w);
                dr_next    = dr_w;
                dc_next    = dc_w;
                acc_next   = '0;
                first_next = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                rd_v_next = 1'b1;
                if (cc_reg == cur_c_reg)
                begin
                    cc_next    = c0_reg;
                    rr_next    = rr_reg + 1'b1;
                    rslot_next = (rslot_reg == SLOT_W'(MAX_WINDOW - 1))
                                 ? '0 : rslot_reg + 1'b1;
                    if (rr_reg == cur_r_reg)
                        state_next = ST_DRAIN;
                end
                else
                begin
                    cc_next = cc_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_v)
                begin
                    if (kind_reg == KIND_MAX)
                        val_next = SAMPLE_BITS'(acc_reg);
                    else if (!acc_reg[SUM_W-1] && (quot > NUM_W'(SAT_HI)))
                        val_next = SAMPLE_BITS'(SAT_HI);
                    else if (acc_reg[SUM_W-1] && (quot > NUM_W'(SAT_HI) + 1'b1))
                        val_next = SAMPLE_BITS'(SAT_HI) + 1'b1;
                    else if (acc_reg[SUM_W-1])
                        val_next = SAMPLE_BITS'(~quot + 1'b1);
                    else
                        val_next = SAMPLE_BITS'(quot);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    if (j_reg == j_hi_reg)
                    begin
                        if (i_reg == i_hi_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + 1'b1;
                            j_next     = j_lo_reg;
                            state_next = ST_SETUP;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_SETUP;
                    end
                end
            end
            default:
            begin
                state_next = ST_GEOM;
                start_next = 1'b1;
            end
        endcase

        // register writes restart the frame and recompute geometry
        if (cfg_we)
        begin
            case (cfg_index)
                REG_POOL_KIND:     kind_next = cfg_data[0];
                REG_PAD_MODE:      mode_next = cfg_data[0];
                REG_WINDOW_SIZE:   ws_next   = cfg_data[KW-1:0];
                REG_STRIDE:        st_next   = cfg_data[KW-1:0];
                REG_IN_HEIGHT:     ih_next   = cfg_data[DIM_W-1:0];
                REG_IN_WIDTH:      iw_next   = cfg_data[DIM_W-1:0];
                REG_CHANNEL_COUNT: ch_next   = cfg_data[DIM_W-1:0];
                default:           ;
            endcase
            if (cfg_index <= REG_CHANNEL_COUNT)
            begin
                prow_next  = '0;
                pcol_next  = '0;
                plane_next = '0;
                slot_next  = '0;
                start_next = 1'b1;
                state_next = ST_GEOM;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= KIND_MAX;
            mode_reg    <= MODE_VALID;
            ws_reg      <= KW'(2);
            st_reg      <= KW'(2);
            ih_reg      <= DIM_W'(64);
            iw_reg      <= DIM_W'(64);
            ch_reg      <= DIM_W'(1);
            state_reg   <= ST_GEOM;
            start_reg   <= 1'b1;
            prow_reg    <= '0;
            pcol_reg    <= '0;
            plane_reg   <= '0;
            slot_reg    <= '0;
            row_i_reg   <= '0;
            row_end_reg <= '0;
            col_j_reg   <= '0;
            col_end_reg <= '0;
            rd_v_reg    <= 1'b0;
        end
        else
        begin
            kind_reg    <= kind_next;
            mode_reg    <= mode_next;
            ws_reg      <= ws_next;
            st_reg      <= st_next;
            ih_reg      <= ih_next;
            iw_reg      <= iw_next;
            ch_reg      <= ch_next;
            state_reg   <= state_next;
            start_reg   <= start_next;
            prow_reg    <= prow_next;
            pcol_reg    <= pcol_next;
            plane_reg   <= plane_next;
            slot_reg    <= slot_next;
            row_i_reg   <= row_i_next;
            row_end_reg <= row_end_next;
            col_j_reg   <= col_j_next;
            col_end_reg <= col_end_next;
            rd_v_reg    <= rd_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_r_reg    <= cur_r_next;
        cur_c_reg    <= cur_c_next;
        cur_ch_reg   <= cur_ch_next;
        cur_slot_reg <= cur_slot_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        i_hi_reg     <= i_hi_next;
        j_lo_reg     <= j_lo_next;
        j_hi_reg     <= j_hi_next;
        rr_reg       <= rr_next;
        cc_reg       <= cc_next;
        c0_reg       <= c0_next;
        rslot_reg    <= rslot_next;
        dr_reg       <= dr_next;
        dc_reg       <= dc_next;
        acc_reg      <= acc_next;
        first_reg    <= first_next;
        val_reg      <= val_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tlast  = (i_reg == i_hi_reg) && (j_reg == j_hi_reg);
    assign m_axis_tdata  = OUT_W'({j_reg, i_reg, cur_ch_reg, val_reg});

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tvalid && s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    a_next_window: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !m_axis_tlast && !cfg_we) |=> (state_reg == ST_SETUP))
        else $error("run ended before its last result");

    a_geom_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!row_busy && !col_busy && !start_reg))
        else $error("input accepted during geometry pass");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        (div_v && !$past(cfg_we, 1) && (state_reg == ST_DIV)) |=> (state_reg == ST_OUT
            || $past(cfg_we, 1)))
        else $error("division result not moved to output");

endmodule

// File: sv/pool2d_axis_geom.sv
// Iterative output count and padding split for one axis of the plane.
module pool2d_axis_geom (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pool2d_pkg::DIM_W-1:0]  n,
    input  logic [pool2d_pkg::KW-1:0]     k,
    input  logic [pool2d_pkg::KW-1:0]     s,
    input  logic                          same,
    output logic                          busy,
    output pool2d_pkg::axis_geom_t        geom
);
    import pool2d_pkg::*;

    logic [7:0]       acc_reg, acc_next;
    logic [DIM_W-1:0] o_reg, o_next;
    logic             busy_reg, busy_next;
    logic [8:0]       pad_w;
    logic [PAD_W-1:0] pad;

    always_comb
    begin
        acc_next  = acc_reg;
        o_next    = o_reg;
        busy_next = busy_reg;
        if (start)
        begin
            acc_next  = same ? 8'd0 : ({4'd0, k} - 8'd1);
            o_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // count window origins until the next one falls past the axis
            if (acc_reg < {1'b0, n})
            begin
                acc_next = acc_reg + {4'd0, s};
                o_next   = o_reg + 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            acc_reg  <= '0;
            o_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            acc_reg  <= acc_next;
            o_reg    <= o_next;
        end
    end

    // in same mode acc ends at outn*s, so pad = acc - s + k - n
    assign pad_w = {1'b0, acc_reg} + {5'd0, k} - {5'd0, s} - {2'd0, n};
    assign pad   = same ? PAD_W'(pad_w) : '0;

    assign busy       = busy_reg;
    assign geom.outn  = o_reg;
    assign geom.lead  = pad >> 1;
    assign geom.trail = pad - (pad >> 1);

endmodule

// File: sv/pool2d_line_store.sv
// Line store holding the most recent rows of the current plane.
module pool2d_line_store #(
    parameter  int SAMPLE_BITS = 16,
    parameter  int MAX_WINDOW  = 8,
    parameter  int MAX_WIDTH   = 64,
    localparam int SLOT_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int CIDX_W      = $clog2(MAX_WIDTH)
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [SLOT_W-1:0]      wslot,
    input  logic [CIDX_W-1:0]      wcol,
    input  logic [SAMPLE_BITS-1:0] wdata,
    input  logic [SLOT_W-1:0]      rslot,
    input  logic [CIDX_W-1:0]      rcol,
    output logic [SAMPLE_BITS-1:0] rdata
);
    localparam int DEPTH  = MAX_WINDOW * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [ADDR_W-1:0]      waddr;
    logic [ADDR_W-1:0]      raddr;

    assign waddr = ADDR_W'(int'(wslot) * MAX_WIDTH + int'(wcol));
    assign raddr = ADDR_W'(int'(rslot) * MAX_WIDTH + int'(rcol));

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/pool2d_div_cell.sv
// One restoring-division cell: retires one quotient bit per beat.
module pool2d_div_cell #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [DEN_W-1:0] in_rem,
    input  logic [NUM_W-1:0] in_nq,
    input  logic [DEN_W-1:0] in_den,
    output logic             out_valid,
    output logic [DEN_W-1:0] out_rem,
    output logic [NUM_W-1:0] out_nq,
    output logic [DEN_W-1:0] out_den
);
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] nq_next;

    always_comb
    begin
        trial    = {in_rem, in_nq[NUM_W-1]};
        ge       = trial >= {1'b0, in_den};
        rem_next = ge ? DEN_W'(trial - {1'b0, in_den}) : DEN_W'(trial);
        // shift the numerator out and the quotient bit in
        nq_next  = {in_nq[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rem <= rem_next;
        out_nq  <= nq_next;
        out_den <= in_den;
    end

endmodule

// File: sv/pool2d_div_chain.sv
// Chain of division cells producing the rounded average quotient.
module pool2d_div_chain #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    output logic             out_valid,
    output logic [NUM_W-1:0] out_quot
);
    logic             v   [NUM_W+1];
    logic [DEN_W-1:0] rem [NUM_W+1];
    logic [NUM_W-1:0] nq  [NUM_W+1];
    logic [DEN_W-1:0] den [NUM_W+1];

    assign v[0]   = in_valid;
    assign rem[0] = '0;
    assign nq[0]  = in_num;
    assign den[0] = in_den;

    for (genvar g = 0; g < NUM_W; g++)
    begin : g_cell
        pool2d_div_cell #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v[g]),
            .in_rem    (rem[g]),
            .in_nq     (nq[g]),
            .in_den    (den[g]),
            .out_valid (v[g+1]),
            .out_rem   (rem[g+1]),
            .out_nq    (nq[g+1]),
            .out_den   (den[g+1])
        );
    end

    assign out_valid = v[NUM_W];
    assign out_quot  = nq[NUM_W];

endmodule
